// ===== hdl/spi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment/plane intersection package
// Shared word types and fixed constants of the segment/plane intersection core.
// ----------------------------------------------------------------------------
package spi_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned NormW  = 18;
  localparam int unsigned DiffW  = 33;
  localparam int unsigned ProdW  = 51;
  localparam int unsigned DotW   = 53;
  localparam int unsigned RemW   = 54;
  localparam int unsigned SBits  = 30;
  localparam int unsigned SW     = 31;
  localparam int unsigned LerpW  = 64;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegNormalX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegNormalY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegNormalZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAnchorX = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAnchorY = 3'd4;
  localparam logic [CfgIdxW-1:0] RegAnchorZ = 3'd5;

  typedef enum logic {
    JobPlane = 1'b0,
    JobCross = 1'b1
  } job_kind_e;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
  } seg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] hit_x;
    logic signed [CoordW-1:0] hit_y;
    logic signed [CoordW-1:0] hit_z;
    logic                     point_kind;
    logic                     last;
  } hit_t;

  typedef struct packed {
    logic signed [NormW-1:0]  normal_x;
    logic signed [NormW-1:0]  normal_y;
    logic signed [NormW-1:0]  normal_z;
    logic signed [CoordW-1:0] anchor_x;
    logic signed [CoordW-1:0] anchor_y;
    logic signed [CoordW-1:0] anchor_z;
  } plane_t;

  typedef struct packed {
    job_kind_e               kind;
    seg_t                    seg;
    logic signed [DiffW-1:0] u_x;
    logic signed [DiffW-1:0] u_y;
    logic signed [DiffW-1:0] u_z;
    logic [DotW-1:0]         mag_d;
    logic [DotW-1:0]         mag_n;
  } job_t;

endpackage
`default_nettype wire

// ===== hdl/spi_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment/plane intersection front end
// Three-stage pipeline that forms D and N for each segment, classifies it and
// hands plane and crossing jobs to the job queue. Parallel misses and segments that do not cross are dropped.
// ----------------------------------------------------------------------------
module spi_front #(
  parameter int unsigned PARALLEL_EPSILON = 1,
  parameter int unsigned FRAC_BITS        = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire spi_pkg::plane_t plane_i,
  input  wire logic            push,
  output logic                 full,
  input  wire spi_pkg::seg_t   seg_i,
  output logic                 job_push_o,
  output spi_pkg::job_t        job_o,
  input  wire logic            job_full_i
);

  localparam logic [spi_pkg::DotW-1:0] Thr =
    spi_pkg::DotW'(PARALLEL_EPSILON) << FRAC_BITS;

  logic adv;
  logic v1_q, v2_q, v3_q;
  spi_pkg::seg_t seg1_q, seg2_q, seg3_q;
  logic signed [spi_pkg::DiffW-1:0] u1_q [3];
  logic signed [spi_pkg::DiffW-1:0] w1_q [3];
  logic signed [spi_pkg::DiffW-1:0] u2_q [3];
  logic signed [spi_pkg::DiffW-1:0] u3_q [3];
  logic signed [spi_pkg::ProdW-1:0] pd_q [3];
  logic signed [spi_pkg::ProdW-1:0] pn_q [3];
  logic signed [spi_pkg::DotW-1:0]  d3_q, n3_q;
  logic signed [spi_pkg::NormW-1:0] nrm [3];
  logic signed [spi_pkg::CoordW-1:0] anc [3];
  logic signed [spi_pkg::CoordW-1:0] st [3];
  logic signed [spi_pkg::CoordW-1:0] en [3];
  logic [spi_pkg::DotW-1:0] mag_d, mag_n;
  logic parallel, keep, is_cross;

  assign nrm = '{plane_i.normal_x, plane_i.normal_y, plane_i.normal_z};
  assign anc = '{plane_i.anchor_x, plane_i.anchor_y, plane_i.anchor_z};
  assign st  = '{seg_i.start_x, seg_i.start_y, seg_i.start_z};
  assign en  = '{seg_i.end_x, seg_i.end_y, seg_i.end_z};

  assign mag_d = d3_q[spi_pkg::DotW-1] ? spi_pkg::DotW'(-d3_q) : spi_pkg::DotW'(d3_q);
  assign mag_n = n3_q[spi_pkg::DotW-1] ? spi_pkg::DotW'(-n3_q) : spi_pkg::DotW'(n3_q);
  assign parallel = (d3_q == '0) || (mag_d < Thr);
  assign is_cross = ((n3_q == '0) || (n3_q[spi_pkg::DotW-1] == d3_q[spi_pkg::DotW-1]))
                    && (mag_n <= mag_d);
  assign keep = parallel ? (n3_q == '0) : is_cross;

  assign adv        = !(v3_q && keep && job_full_i);
  assign full       = !adv;
  assign job_push_o = v3_q && keep && !job_full_i;

  always_comb begin
    job_o.kind  = parallel ? spi_pkg::JobPlane : spi_pkg::JobCross;
    job_o.seg   = seg3_q;
    job_o.u_x   = u3_q[0];
    job_o.u_y   = u3_q[1];
    job_o.u_z   = u3_q[2];
    job_o.mag_d = mag_d;
    job_o.mag_n = mag_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= push;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      seg1_q <= seg_i;
      seg2_q <= seg1_q;
      seg3_q <= seg2_q;
      for (int i = 0; i < 3; i++) begin
        u1_q[i] <= spi_pkg::DiffW'(en[i]) - spi_pkg::DiffW'(st[i]);
        w1_q[i] <= spi_pkg::DiffW'(st[i]) - spi_pkg::DiffW'(anc[i]);
        pd_q[i] <= spi_pkg::ProdW'(nrm[i]) * spi_pkg::ProdW'(u1_q[i]);
        pn_q[i] <= spi_pkg::ProdW'(nrm[i]) * spi_pkg::ProdW'(w1_q[i]);
        u2_q[i] <= u1_q[i];
        u3_q[i] <= u2_q[i];
      end
      d3_q <= spi_pkg::DotW'(pd_q[0]) + spi_pkg::DotW'(pd_q[1]) + spi_pkg::DotW'(pd_q[2]);
      n3_q <= -(spi_pkg::DotW'(pn_q[0]) + spi_pkg::DotW'(pn_q[1])
                + spi_pkg::DotW'(pn_q[2]));
    end
  end

endmodule
`default_nettype wire

// ===== hdl/spi_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment/plane intersection job queue
// Short queue of classified jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module spi_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  wire spi_pkg::job_t wdata_i,
  output logic               full_o,
  input  wire logic          rd_i,
  output spi_pkg::job_t      rdata_o,
  output logic               empty_o
);

  spi_pkg::job_t mem_q [spi_pkg::QDepth];
  logic [spi_pkg::QPtrW-1:0] wp_q, rp_q;
  logic [spi_pkg::QCntW-1:0] cnt_q;
  logic do_wr, do_rd;

  assign full_o  = (cnt_q == spi_pkg::QCntW'(spi_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= wp_q + 1'b1;
      if (do_rd) rp_q <= rp_q + 1'b1;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wdata_i;
  end

endmodule
`default_nettype wire

// ===== hdl/spi_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment/plane intersection back end
// Emits both endpoints of in-plane segments, or divides N by D one bit per
// cycle and interpolates the crossing point one axis at a time.
// ----------------------------------------------------------------------------
module spi_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_empty_i,
  input  wire spi_pkg::job_t job_i,
  output logic               job_pop_o,
  output logic               empty,
  input  wire logic          pop,
  output spi_pkg::hit_t      hit_o
);

  typedef enum logic [2:0] {
    StIdle, StStart, StEnd, StDiv, StMul, StAdd, StEmit
  } state_e;

  state_e state_q;
  spi_pkg::job_t job_q;
  logic out_v_q;
  spi_pkg::hit_t out_q;
  logic [spi_pkg::RemW-1:0] r_q;
  logic [spi_pkg::SW-1:0] s_q;
  logic [4:0] cnt_q;
  logic [1:0] axis_q;
  logic [spi_pkg::LerpW-1:0] prod_q;
  logic signed [spi_pkg::CoordW-1:0] hit_q [3];

  logic out_free;
  logic emit;
  logic [spi_pkg::RemW-1:0] rt;
  logic signed [spi_pkg::DiffW-1:0] u_sel;
  logic signed [spi_pkg::CoordW-1:0] st_sel;
  logic [spi_pkg::DiffW-1:0] u_mag;
  logic [spi_pkg::LerpW-1:0] rnd;
  logic [spi_pkg::CoordW-1:0] dlt;

  assign out_free  = !out_v_q || pop;
  assign emit      = out_free &&
                     ((state_q == StStart) || (state_q == StEnd) || (state_q == StEmit));
  assign empty     = !out_v_q;
  assign hit_o     = out_q;
  assign job_pop_o = (state_q == StIdle) && !job_empty_i;

  assign rt = (cnt_q == '0) ? r_q : {r_q[spi_pkg::RemW-2:0], 1'b0};

  always_comb begin
    unique case (axis_q)
      2'd0:    begin u_sel = job_q.u_x; st_sel = job_q.seg.start_x; end
      2'd1:    begin u_sel = job_q.u_y; st_sel = job_q.seg.start_y; end
      default: begin u_sel = job_q.u_z; st_sel = job_q.seg.start_z; end
    endcase
  end

  assign u_mag = u_sel[spi_pkg::DiffW-1] ? spi_pkg::DiffW'(-u_sel) : spi_pkg::DiffW'(u_sel);
  assign rnd   = prod_q + (spi_pkg::LerpW'(1) << (spi_pkg::SBits - 1));
  assign dlt   = rnd[spi_pkg::SBits +: spi_pkg::CoordW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_v_q <= 1'b0;
      cnt_q   <= '0;
      axis_q  <= '0;
    end else begin
      if (emit) out_v_q <= 1'b1;
      else if (pop) out_v_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (!job_empty_i) begin
            job_q <= job_i;
            r_q   <= spi_pkg::RemW'(job_i.mag_n);
            s_q   <= '0;
            cnt_q <= '0;
            state_q <= (job_i.kind == spi_pkg::JobPlane) ? StStart : StDiv;
          end
        end
        StStart: begin
          if (out_free) begin
            out_q <= '{hit_x: job_q.seg.start_x, hit_y: job_q.seg.start_y,
                       hit_z: job_q.seg.start_z, point_kind: 1'b1, last: 1'b0};
            state_q <= StEnd;
          end
        end
        StEnd: begin
          if (out_free) begin
            out_q <= '{hit_x: job_q.seg.end_x, hit_y: job_q.seg.end_y,
                       hit_z: job_q.seg.end_z, point_kind: 1'b1, last: 1'b1};
            state_q <= StIdle;
          end
        end
        StDiv: begin
          if (rt >= spi_pkg::RemW'(job_q.mag_d)) begin
            r_q <= rt - spi_pkg::RemW'(job_q.mag_d);
            s_q <= {s_q[spi_pkg::SW-2:0], 1'b1};
          end else begin
            r_q <= rt;
            s_q <= {s_q[spi_pkg::SW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'(spi_pkg::SBits)) begin
            axis_q  <= '0;
            state_q <= StMul;
          end
        end
        StMul: begin
          prod_q  <= spi_pkg::LerpW'(u_mag) * spi_pkg::LerpW'(s_q);
          state_q <= StAdd;
        end
        StAdd: begin
          hit_q[axis_q] <= u_sel[spi_pkg::DiffW-1] ? st_sel - dlt : st_sel + dlt;
          if (axis_q == 2'd2) begin
            state_q <= StEmit;
          end else begin
            axis_q  <= axis_q + 1'b1;
            state_q <= StMul;
          end
        end
        StEmit: begin
          if (out_free) begin
            out_q <= '{hit_x: hit_q[0], hit_y: hit_q[1], hit_z: hit_q[2],
                       point_kind: 1'b0, last: 1'b1};
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/segment_plane_intersection_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment/plane intersection core
// Intersects segments with a configured plane in Q16.16 fixed point.
//
// Channel   Direction  Handshake            Word
// segment   in         push / full          spi_pkg::seg_t
// result    out        pop / empty          spi_pkg::hit_t
// config    in         cfg_we_i, no stall   cfg_idx_i, cfg_data_i
//
// The front pipeline takes one segment per cycle while full is low, passes it
// through its v1, v2 and v3 registers and classifies it into a four-entry job
// queue. An in-plane segment gives two words. A crossing runs the
// one-bit-per-cycle restoring divider and then the shared lerp multiplier per axis.
// Full rises when the job queue is full and a kept job waits in the last front stage.
// Reset loads the normal as (0, 0, 1.0) and the anchor as the origin.
// ----------------------------------------------------------------------------
module segment_plane_intersection_core #(
  parameter int unsigned PARALLEL_EPSILON = 1,
  parameter int unsigned FRAC_BITS        = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [spi_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [spi_pkg::CoordW-1:0]     cfg_data_i,
  input  wire logic                           push,
  output logic                                full,
  input  wire spi_pkg::seg_t                  seg_i,
  output logic                                empty,
  input  wire logic                           pop,
  output spi_pkg::hit_t                       hit_o
);

  spi_pkg::plane_t plane_q;
  spi_pkg::job_t job_w, job_r;
  logic job_push, job_full, job_pop, job_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '{normal_x: '0, normal_y: '0,
                   normal_z: spi_pkg::NormW'(1 << FRAC_BITS),
                   anchor_x: '0, anchor_y: '0, anchor_z: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spi_pkg::RegNormalX: plane_q.normal_x <= cfg_data_i[spi_pkg::NormW-1:0];
        spi_pkg::RegNormalY: plane_q.normal_y <= cfg_data_i[spi_pkg::NormW-1:0];
        spi_pkg::RegNormalZ: plane_q.normal_z <= cfg_data_i[spi_pkg::NormW-1:0];
        spi_pkg::RegAnchorX: plane_q.anchor_x <= cfg_data_i;
        spi_pkg::RegAnchorY: plane_q.anchor_y <= cfg_data_i;
        spi_pkg::RegAnchorZ: plane_q.anchor_z <= cfg_data_i;
        default: ;
      endcase
    end
  end

  spi_front #(
    .PARALLEL_EPSILON(PARALLEL_EPSILON),
    .FRAC_BITS       (FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .plane_i   (plane_q),
    .push      (push),
    .full      (full),
    .seg_i     (seg_i),
    .job_push_o(job_push),
    .job_o     (job_w),
    .job_full_i(job_full)
  );

  spi_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (job_push),
    .wdata_i(job_w),
    .full_o (job_full),
    .rd_i   (job_pop),
    .rdata_o(job_r),
    .empty_o(job_empty)
  );

  spi_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(job_empty),
    .job_i      (job_r),
    .job_pop_o  (job_pop),
    .empty      (empty),
    .pop        (pop),
    .hit_o      (hit_o)
  );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment/plane intersection core testbench
// Sends segments against several plane settings. The settings include extreme,
// unnormalized and tiny normals. An internal fixed-point model predicts every
// hit word, and each popped word is checked field by field against it. The
// sender and the receiver idle at random, and a long receiver hold-off fills
// the core.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned Eps  = 1;
  localparam int unsigned Frac = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [spi_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [spi_pkg::CoordW-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  spi_pkg::seg_t seg = '0;
  logic empty;
  logic pop = 1'b0;
  spi_pkg::hit_t hit;

  logic signed [spi_pkg::NormW-1:0] normal_reg[3];
  logic signed [spi_pkg::CoordW-1:0] anchor_reg[3];
  spi_pkg::hit_t hit_q[$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  segment_plane_intersection_core #(
    .PARALLEL_EPSILON(Eps),
    .FRAC_BITS(Frac)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .push(push),
    .full(full),
    .seg_i(seg),
    .empty(empty),
    .pop(pop),
    .hit_o(hit)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("segment_plane_intersection_core test failed");
    $finish;
  end

  function automatic void predict_hits(spi_pkg::seg_t sg);
    longint signed st[3], en[3], u[3], nrm[3], anc[3];
    longint signed d, n;
    logic [127:0] ad, an, s, um, dm;
    logic [spi_pkg::CoordW-1:0] px[3];
    spi_pkg::hit_t h;
    st[0] = sg.start_x; st[1] = sg.start_y; st[2] = sg.start_z;
    en[0] = sg.end_x; en[1] = sg.end_y; en[2] = sg.end_z;
    d = 0;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      nrm[i] = normal_reg[i];
      anc[i] = anchor_reg[i];
      u[i] = en[i] - st[i];
      d += nrm[i] * u[i];
      n -= nrm[i] * (st[i] - anc[i]);
    end
    ad = 128'(d < 0 ? -d : d);
    an = 128'(n < 0 ? -n : n);
    if (d == 0 || ad < (128'(Eps) << Frac)) begin
      if (n == 0) begin
        h = '{sg.start_x, sg.start_y, sg.start_z, 1'b1, 1'b0};
        hit_q = {hit_q, h};
        h = '{sg.end_x, sg.end_y, sg.end_z, 1'b1, 1'b1};
        hit_q = {hit_q, h};
      end
    end else if ((n == 0 || ((n < 0) == (d < 0))) && an <= ad) begin
      s = (an << spi_pkg::SBits) / ad;
      for (int i = 0; i < 3; i++) begin
        um = 128'(u[i] < 0 ? -u[i] : u[i]);
        dm = (um * s + (128'd1 << (spi_pkg::SBits - 1))) >> spi_pkg::SBits;
        px[i] = (u[i] < 0) ? spi_pkg::CoordW'(st[i] - longint'(dm))
                           : spi_pkg::CoordW'(st[i] + longint'(dm));
      end
      h = '{px[0], px[1], px[2], 1'b0, 1'b1};
      hit_q = {hit_q, h};
    end
  endfunction

  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    spi_pkg::hit_t exp_hit;
    if (rst_n && pop && !empty) begin
      if (hit_q.size() == 0) begin
        $error("unexpected word: x=%0h y=%0h z=%0h", hit.hit_x, hit.hit_y, hit.hit_z);
        errors++;
      end else begin
        exp_hit = hit_q.pop_front();
        if (hit.hit_x !== exp_hit.hit_x) begin
          $error("hit_x: expected %0h, got %0h", exp_hit.hit_x, hit.hit_x);
          errors++;
        end
        if (hit.hit_y !== exp_hit.hit_y) begin
          $error("hit_y: expected %0h, got %0h", exp_hit.hit_y, hit.hit_y);
          errors++;
        end
        if (hit.hit_z !== exp_hit.hit_z) begin
          $error("hit_z: expected %0h, got %0h", exp_hit.hit_z, hit.hit_z);
          errors++;
        end
        if (hit.point_kind !== exp_hit.point_kind) begin
          $error("point_kind: expected %0b, got %0b", exp_hit.point_kind, hit.point_kind);
          errors++;
        end
        if (hit.last !== exp_hit.last) begin
          $error("last: expected %0b, got %0b", exp_hit.last, hit.last);
          errors++;
        end
      end
    end
  end

  task automatic send_segment(spi_pkg::seg_t sg);
    if ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    push <= 1'b1;
    seg <= sg;
    do @(posedge clk); while (full);
    predict_hits(sg);
  endtask

  task automatic stop_sending();
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    while (hit_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_plane(spi_pkg::plane_t p);
    logic [spi_pkg::CoordW-1:0] vals[6];
    logic [spi_pkg::CfgIdxW-1:0] idx[6];
    stop_sending();
    wait_drained();
    vals = '{spi_pkg::CoordW'(p.normal_x), spi_pkg::CoordW'(p.normal_y),
             spi_pkg::CoordW'(p.normal_z), p.anchor_x, p.anchor_y, p.anchor_z};
    idx = '{spi_pkg::RegNormalX, spi_pkg::RegNormalY, spi_pkg::RegNormalZ,
            spi_pkg::RegAnchorX, spi_pkg::RegAnchorY, spi_pkg::RegAnchorZ};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      if (i < 3) normal_reg[i] = vals[i][spi_pkg::NormW-1:0];
      else anchor_reg[i-3] = vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic longint signed rand_offset(int bits);
    return longint'($signed($urandom())) >>> (31 - bits);
  endfunction

  function automatic spi_pkg::seg_t mk_seg(longint signed sx, longint signed sy,
                                           longint signed sz, longint signed ex,
                                           longint signed ey, longint signed ez);
    spi_pkg::seg_t sg;
    sg.start_x = spi_pkg::CoordW'(sx);
    sg.start_y = spi_pkg::CoordW'(sy);
    sg.start_z = spi_pkg::CoordW'(sz);
    sg.end_x = spi_pkg::CoordW'(ex);
    sg.end_y = spi_pkg::CoordW'(ey);
    sg.end_z = spi_pkg::CoordW'(ez);
    return sg;
  endfunction

  function automatic spi_pkg::seg_t rand_segment();
    longint signed a[3], p[3], q[3], r1[3], r2[3], nv[3];
    int pick;
    pick = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      a[i] = anchor_reg[i];
      nv[i] = normal_reg[i];
    end
    if (pick < 20) begin
      return mk_seg($signed($urandom()), $signed($urandom()), $signed($urandom()),
                    $signed($urandom()), $signed($urandom()), $signed($urandom()));
    end else if (pick < 75) begin
      for (int i = 0; i < 3; i++) begin
        p[i] = a[i] + rand_offset($urandom_range(4, 24));
        q[i] = a[i] - rand_offset($urandom_range(4, 24));
      end
      if ($urandom_range(9) == 0) p = a;
      if ($urandom_range(9) == 0) q = a;
      return mk_seg(p[0], p[1], p[2], q[0], q[1], q[2]);
    end else if (pick < 90) begin
      // Offsets along n x r are perpendicular to the normal, so the segment lies in the plane unless p is then nudged.
      for (int i = 0; i < 3; i++) begin
        r1[i] = rand_offset(10);
        r2[i] = rand_offset(10);
      end
      for (int i = 0; i < 3; i++) begin
        p[i] = a[i] + nv[(i+1)%3] * r1[(i+2)%3] - nv[(i+2)%3] * r1[(i+1)%3];
        q[i] = a[i] + nv[(i+1)%3] * r2[(i+2)%3] - nv[(i+2)%3] * r2[(i+1)%3];
      end
      if ($urandom_range(3) == 0) p[$urandom_range(2)] += rand_offset(4) | 1;
      return mk_seg(p[0], p[1], p[2], q[0], q[1], q[2]);
    end else begin
      for (int i = 0; i < 3; i++) begin
        p[i] = a[i] + rand_offset(8);
        q[i] = p[i] + rand_offset(6);
      end
      return mk_seg(p[0], p[1], p[2], q[0], q[1], q[2]);
    end
  endfunction

  function automatic spi_pkg::plane_t rand_plane();
    spi_pkg::plane_t p;
    p.normal_x = spi_pkg::NormW'($urandom());
    p.normal_y = spi_pkg::NormW'($urandom());
    p.normal_z = spi_pkg::NormW'($urandom());
    p.anchor_x = ($urandom_range(3) == 0) ? $urandom() : spi_pkg::CoordW'(rand_offset(24));
    p.anchor_y = ($urandom_range(3) == 0) ? $urandom() : spi_pkg::CoordW'(rand_offset(24));
    p.anchor_z = ($urandom_range(3) == 0) ? $urandom() : spi_pkg::CoordW'(rand_offset(24));
    return p;
  endfunction

  task automatic test_directed();
    longint signed mx, mn;
    mx = 64'sh7FFFFFFF;
    mn = -64'sh80000000;
    send_segment(mk_seg(0, 0, 0, 0, 0, 0));
    send_segment(mk_seg(1, 2, -65536, 3, 4, 65536));
    send_segment(mk_seg(5, 6, 0, 7, 8, 100));
    send_segment(mk_seg(5, 6, -100, 7, 8, 0));
    send_segment(mk_seg(0, 0, 5, 9, 9, 5));
    send_segment(mk_seg(0, 0, 10, 0, 0, 20));
    send_segment(mk_seg(mx, mx, mx, mn, mn, mn));
    send_segment(mk_seg(mn, mn, mn, mx, mx, mx));
    send_segment(mk_seg(mx, mn, 0, mn, mx, 0));
    send_segment(mk_seg(-1, -1, -1, -1, -1, 1));
    send_segment(mk_seg(mx, mx, 1, mx, mx, -3));
    send_segment(mk_seg(mn, mn, mn, mn, mn, mx));
    stop_sending();
  endtask

  task automatic test_tiny_normal();
    write_plane('{18'sd0, 18'sd0, 18'sd1, 32'sd0, 32'sd0, 32'sd0});
    send_segment(mk_seg(3, 4, 0, 9, 9, 100));
    send_segment(mk_seg(3, 4, 1, 9, 9, 100));
    send_segment(mk_seg(0, 0, 0, 0, 0, 65536));
    send_segment(mk_seg(0, 0, 0, 0, 0, 65535));
    send_segment(mk_seg(0, 0, -65536, 0, 0, 65536));
    stop_sending();
  endtask

  task automatic test_plane_sweep();
    spi_pkg::plane_t planes[6];
    planes[0] = '{-18'sd65536, 18'sd0, 18'sd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0};
    planes[1] = '{18'sd0, 18'sd65536, 18'sd0, 32'sh80000000, 32'sh7FFFFFFF, 32'sd12345};
    planes[2] = '{18'sd46341, 18'sd0, -18'sd46341, 32'sd65536, 32'sd0, -32'sd65536};
    planes[3] = '{18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF,
                  32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
    planes[4] = '{18'sh20000, 18'sh20000, 18'sh20000,
                  32'sh80000000, 32'sh80000000, 32'sh80000000};
    planes[5] = '{18'sd37837, 18'sd37837, 18'sd37837, -32'sd300000, 32'sd7, 32'sd900000};
    foreach (planes[k]) begin
      write_plane(planes[k]);
      repeat (40) send_segment(rand_segment());
      stop_sending();
    end
  endtask

  task automatic test_idling();
    int tx_pct[4] = '{0, 57, 0, 28};
    int rx_pct[4] = '{0, 0, 57, 28};
    for (int k = 0; k < 4; k++) begin
      write_plane(rand_plane());
      tx_idle_pct = tx_pct[k];
      rx_stall_pct = rx_pct[k];
      repeat (90) send_segment(rand_segment());
      stop_sending();
    end
    tx_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    write_plane('{18'sd0, 18'sd0, 18'sd65536, 32'sd0, 32'sd0, 32'sd0});
    hold_req = 400;
    repeat (40) send_segment(rand_segment());
    stop_sending();
    wait_drained();
    repeat (10) send_segment(rand_segment());
    stop_sending();
  endtask

  initial begin
    normal_reg = '{18'sd0, 18'sd0, 18'sd65536};
    anchor_reg = '{32'sd0, 32'sd0, 32'sd0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_tiny_normal();
    test_plane_sweep();
    test_idling();
    test_backpressure();
    wait_drained();
    if (errors == 0) begin
      $display("segment_plane_intersection_core test passed");
    end else begin
      $display("segment_plane_intersection_core test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/spi_pkg.sv
hdl/spi_front.sv
hdl/spi_queue.sv
hdl/spi_back.sv
hdl/segment_plane_intersection_core.sv
sim/testbench.sv
